FILE: hdl/u8u16_pkg.sv
// shared types and constants for the utf-8 to utf-16 transcoder
// no dependencies; imported by u8u16_decode, utf8_to_utf16_transcoder and utf16_unit_checker
`timescale 1ns / 1ps
`default_nettype none

package u8u16_pkg;

    localparam int CP_W   = 21;
    localparam int UNIT_W = 16;

    // lead and continuation byte classes
    localparam logic [7:0] MASK_2B  = 8'hE0;
    localparam logic [7:0] LEAD_2B  = 8'hC0;
    localparam logic [7:0] MASK_3B  = 8'hF0;
    localparam logic [7:0] LEAD_3B  = 8'hE0;
    localparam logic [7:0] MASK_4B  = 8'hF8;
    localparam logic [7:0] LEAD_4B  = 8'hF0;
    localparam logic [7:0] MASK_CONT = 8'hC0;
    localparam logic [7:0] CONT_TAG  = 8'h80;

    // code point limits
    localparam logic [CP_W-1:0] CP_SPACE   = 21'h000020;
    localparam logic [CP_W-1:0] CP_DEL     = 21'h00007F;
    localparam logic [CP_W-1:0] CP_BMP_MAX = 21'h00FFFF;
    localparam logic [CP_W-1:0] CP_MAX     = 21'h10FFFF;
    localparam logic [CP_W-1:0] CP_SUPP    = 21'h010000;

    localparam logic [5:0] HI_SURR_TAG = 6'b110110;
    localparam logic [5:0] LO_SURR_TAG = 6'b110111;

    typedef logic [1:0] count_t;
    localparam count_t CNT_NONE = 2'd0;
    localparam count_t CNT_ONE  = 2'd1;
    localparam count_t CNT_TWO  = 2'd2;

    // what one byte yields: zero, one or two units
    typedef struct packed {
        count_t              count;
        logic [UNIT_W-1:0]   unit0;
        logic                last0;
        logic [UNIT_W-1:0]   unit1;
    } dec_result_t;

endpackage

`default_nettype wire

FILE: hdl/u8u16_decode.sv
// utf-8 byte decoder: sequence state and code point to utf-16 units
// depends on u8u16_pkg
`timescale 1ns / 1ps
`default_nettype none

module u8u16_decode
    import u8u16_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        step,
    input  wire logic [7:0]  text_byte,
    input  wire logic        end_of_text,
    output dec_result_t      result
);

    logic [CP_W-1:0] partial_reg, partial_next;
    logic [1:0]      need_reg, need_next;
    logic            halted_reg, halted_next;

    logic [CP_W-1:0] cp;
    logic            have_cp;
    logic [CP_W-1:0] cont_cp;
    logic [19:0]     supp;
    logic            keep;

    assign cont_cp = {partial_reg[CP_W-7:0], text_byte[5:0]};

    always_comb
    begin
        partial_next = partial_reg;
        need_next    = need_reg;
        halted_next  = halted_reg;
        cp           = '0;
        have_cp      = 1'b0;
        if (!halted_reg)
        begin
            if (need_reg == 2'd0)
            begin
                priority if (!text_byte[7])
                begin
                    cp      = {13'd0, text_byte};
                    have_cp = 1'b1;
                end
                else if ((text_byte & MASK_2B) == LEAD_2B)
                begin
                    partial_next = {16'd0, text_byte[4:0]};
                    need_next    = 2'd1;
                end
                else if ((text_byte & MASK_3B) == LEAD_3B)
                begin
                    partial_next = {17'd0, text_byte[3:0]};
                    need_next    = 2'd2;
                end
                else if ((text_byte & MASK_4B) == LEAD_4B)
                begin
                    partial_next = {18'd0, text_byte[2:0]};
                    need_next    = 2'd3;
                end
                else
                begin
                    halted_next = 1'b1;
                end
            end
            else if ((text_byte & MASK_CONT) != CONT_TAG)
            begin
                partial_next = '0;
                need_next    = 2'd0;
                halted_next  = 1'b1;
            end
            else
            begin
                need_next = need_reg - 2'd1;
                if (need_reg == 2'd1)
                begin
                    cp           = cont_cp;
                    have_cp      = 1'b1;
                    partial_next = '0;
                end
                else
                begin
                    partial_next = cont_cp;
                end
            end
        end
        if (end_of_text)
        begin
            partial_next = '0;
            need_next    = 2'd0;
            halted_next  = 1'b0;
        end
    end

    // drop controls, delete and anything past the last plane
    assign keep = have_cp && (cp >= CP_SPACE) && (cp != CP_DEL) && (cp <= CP_MAX);
    assign supp = 20'(cp - CP_SUPP);

    always_comb
    begin
        result.count = CNT_NONE;
        result.unit0 = cp[UNIT_W-1:0];
        result.last0 = 1'b1;
        result.unit1 = {LO_SURR_TAG, supp[9:0]};
        if (keep)
        begin
            if (cp <= CP_BMP_MAX)
            begin
                result.count = CNT_ONE;
            end
            else
            begin
                result.count = CNT_TWO;
                result.unit0 = {HI_SURR_TAG, supp[19:10]};
                result.last0 = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            partial_reg <= '0;
            need_reg    <= 2'd0;
            halted_reg  <= 1'b0;
        end
        else if (step)
        begin
            partial_reg <= partial_next;
            need_reg    <= need_next;
            halted_reg  <= halted_next;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/utf8_to_utf16_transcoder.sv
// top level of the utf-8 to utf-16 transcoder: input register, decoder, result register
// depends on u8u16_pkg and u8u16_decode
`timescale 1ns / 1ps
`default_nettype none

// usage
//   s_axis carries utf-8 text one byte per request: tdata[7:0] is the byte,
//   tlast marks the last byte of a string and clears the decoder state
//   m_axis carries utf-16 code units: tdata[15:0] is the unit, tlast is high
//   on a single unit or the low surrogate of a pair, low on a high surrogate
//   decode path: an accepted byte waits in the input register, is decoded
//   from it and its first unit is loaded into the result register, which
//   drives m_axis; a low surrogate moves up once its high half is taken
//   throughput: one byte per cycle while the receiver keeps up, set by the
//   single decode pass between the input register and the result register;
//   a surrogate pair holds the result register until both halves are taken,
//   so the next byte that gives a unit waits behind the pair
//   bytes that give no unit (lead bytes, bad or dropped input) pass through
//   the decoder without touching the result register
//   when m_axis stalls the result and pending low surrogate hold, the next
//   byte that gives a unit waits in the input register, and s_axis_tready
//   drops until the result is taken
//   reset (rst_n low, asynchronous) empties both registers and clears the
//   sequence state, as if a string had just ended
module utf8_to_utf16_transcoder
    import u8u16_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] text_byte
    input  wire logic        s_axis_tlast,   // end_of_text
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata,   // [15:0] utf16_unit
    output logic             m_axis_tlast    // last_unit
);

    // input register
    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        in_last_reg;

    // result register and the waiting low surrogate
    logic              out_valid_reg;
    logic [UNIT_W-1:0] out_unit_reg;
    logic              out_last_reg;
    logic              pend_valid_reg;
    logic [UNIT_W-1:0] pend_unit_reg;

    dec_result_t dec;
    logic        out_free;
    logic        advance;
    logic        s_accept;

    u8u16_decode u_decode (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (advance),
        .text_byte   (in_byte_reg),
        .end_of_text (in_last_reg),
        .result      (dec)
    );

    // result register frees up when it is empty or its last unit leaves now
    assign out_free = !out_valid_reg || (m_axis_tready && !pend_valid_reg);
    // a byte with no unit never waits on the output side
    assign advance  = in_valid_reg && ((dec.count == CNT_NONE) || out_free);
    assign s_axis_tready = !in_valid_reg || advance;
    assign s_accept = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_accept)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            in_byte_reg <= s_axis_tdata;
            in_last_reg <= s_axis_tlast;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else if (advance && (dec.count != CNT_NONE))
        begin
            out_valid_reg  <= 1'b1;
            pend_valid_reg <= (dec.count == CNT_TWO);
        end
        else if (out_valid_reg && m_axis_tready)
        begin
            // low surrogate moves up, or the register empties
            out_valid_reg  <= pend_valid_reg;
            pend_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && (dec.count != CNT_NONE))
        begin
            out_unit_reg  <= dec.unit0;
            out_last_reg  <= dec.last0;
            pend_unit_reg <= dec.unit1;
        end
        else if (out_valid_reg && m_axis_tready && pend_valid_reg)
        begin
            out_unit_reg <= pend_unit_reg;
            out_last_reg <= 1'b1;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_unit_reg;
    assign m_axis_tlast  = out_last_reg;

`ifndef NO_ASSERTIONS
    // a waiting low surrogate always sits behind a shown high surrogate
    a_pend_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg |-> (out_valid_reg && !out_last_reg))
        else $error("low surrogate pending without its high half");

    a_high_has_low: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_last_reg) |->
            (pend_valid_reg && (out_unit_reg[15:10] == HI_SURR_TAG)))
        else $error("high surrogate shown without a pending low half");

    a_pend_is_low: assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg |-> (pend_unit_reg[15:10] == LO_SURR_TAG))
        else $error("pending unit is not a low surrogate");

    a_empty_takes: assert property (@(posedge clk) disable iff (!rst_n)
        !in_valid_reg |-> s_axis_tready)
        else $error("input refused while the input register is empty");

    a_high_then_low: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_last_reg && m_axis_tready) |=>
            (out_valid_reg && out_last_reg && (out_unit_reg[15:10] == LO_SURR_TAG)))
        else $error("high surrogate not followed by its low half");
`endif

endmodule

`default_nettype wire

FILE: tb/utf16_unit_checker.sv
// scoreboard for the utf-8 to utf-16 transcoder: decodes every accepted byte
// itself and compares each accepted utf-16 unit with the oldest pending one
// depends on u8u16_pkg for the code point limits and surrogate tags
`timescale 1ns / 1ps

module utf16_unit_checker
    import u8u16_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] text_byte
    input  logic        s_axis_tlast,   // end_of_text
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [15:0] m_axis_tdata,   // [15:0] utf16_unit
    input  logic        m_axis_tlast,   // last_unit
    output int          fail_count,
    output int          units_pending
);

    typedef struct packed {
        logic [UNIT_W-1:0] unit;
        logic              last;
    } utf16_unit_t;

    utf16_unit_t       pending_units [$];
    utf16_unit_t       oldest;
    logic [CP_W-1:0]   cp_accum;
    logic [1:0]        cont_left;
    logic              text_halted;
    int                failures = 0;

    // queue the units of one finished code point, or nothing if it is dropped
    function automatic void queue_code_point(input logic [CP_W-1:0] cp);
        logic [CP_W-1:0] offset;
        if (cp < CP_SPACE || cp == CP_DEL || cp > CP_MAX)
            return;
        if (cp <= CP_BMP_MAX)
        begin
            pending_units.push_back({cp[UNIT_W-1:0], 1'b1});
            return;
        end
        offset = cp - CP_SUPP;
        pending_units.push_back({HI_SURR_TAG, offset[19:10], 1'b0});
        pending_units.push_back({LO_SURR_TAG, offset[9:0], 1'b1});
    endfunction

    function automatic void decode_text_byte(input logic [7:0] b, input logic end_of_text);
        if (!text_halted)
        begin
            if (cont_left == 2'd0)
            begin
                if (b[7] == 1'b0)
                    queue_code_point({{(CP_W-8){1'b0}}, b});
                else if ((b & MASK_2B) == LEAD_2B)
                begin
                    cp_accum  = {{(CP_W-5){1'b0}}, b[4:0]};
                    cont_left = 2'd1;
                end
                else if ((b & MASK_3B) == LEAD_3B)
                begin
                    cp_accum  = {{(CP_W-4){1'b0}}, b[3:0]};
                    cont_left = 2'd2;
                end
                else if ((b & MASK_4B) == LEAD_4B)
                begin
                    cp_accum  = {{(CP_W-3){1'b0}}, b[2:0]};
                    cont_left = 2'd3;
                end
                else
                    text_halted = 1'b1;   // stray continuation or 11111xxx
            end
            else if ((b & MASK_CONT) != CONT_TAG)
            begin
                // broken sequence: drop what was gathered, ignore rest of string
                cp_accum    = '0;
                cont_left   = 2'd0;
                text_halted = 1'b1;
            end
            else
            begin
                cp_accum  = {cp_accum[CP_W-7:0], b[5:0]};
                cont_left = cont_left - 2'd1;
                if (cont_left == 2'd0)
                begin
                    queue_code_point(cp_accum);
                    cp_accum = '0;
                end
            end
        end
        // end of string clears everything, including a sequence cut short
        if (end_of_text)
        begin
            cp_accum    = '0;
            cont_left   = 2'd0;
            text_halted = 1'b0;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cp_accum    = '0;
            cont_left   = 2'd0;
            text_halted = 1'b0;
            pending_units.delete();
            units_pending <= 0;
            fail_count    <= failures;
        end
        else
        begin
            // check outputs first: a unit never belongs to a byte taken at the same edge
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (pending_units.size() == 0)
                begin
                    failures++;
                    $display("%0t ns: unit with nothing pending, expected none, actual %h last %b",
                             $time, m_axis_tdata, m_axis_tlast);
                end
                else
                begin
                    oldest = pending_units.pop_front();
                    if (m_axis_tdata !== oldest.unit)
                    begin
                        failures++;
                        $display("%0t ns: utf16_unit expected %h, actual %h",
                                 $time, oldest.unit, m_axis_tdata);
                    end
                    if (m_axis_tlast !== oldest.last)
                    begin
                        failures++;
                        $display("%0t ns: last_unit expected %b, actual %b (unit %h)",
                                 $time, oldest.last, m_axis_tlast, oldest.unit);
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                decode_text_byte(s_axis_tdata, s_axis_tlast);
            units_pending <= pending_units.size();
            fail_count    <= failures;
        end
    end

endmodule

FILE: tb/testbench.sv
// top of the transcoder testbench: clock, reset, utf-8 text stimulus, receiver
// back-pressure and the verdict; checking lives in utf16_unit_checker
// depends on u8u16_pkg, utf8_to_utf16_transcoder and utf16_unit_checker
`timescale 1ns / 1ps

module testbench;

    // far above the slowest correct run
    localparam int CYCLE_LIMIT   = 200000;
    localparam int RANDOM_BYTES  = 800;
    localparam int PHASE_BYTES   = 110;
    localparam int LONG_HOLD     = 300;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;   // [7:0] text_byte
    logic        s_axis_tlast = 1'b0;    // end_of_text
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;           // [15:0] utf16_unit
    logic        m_axis_tlast;           // last_unit

    int          fail_count;
    int          units_pending;
    int          cycle_count = 0;

    // idling modes per phase: steady means no gaps on that side
    logic        tx_steady = 1'b0;
    logic        rx_steady = 1'b0;
    logic        rx_hold_request = 1'b0;

    logic [7:0]  text_buf [$];
    int          bytes_sent = 0;

    always #5 clk = ~clk;

    utf8_to_utf16_transcoder dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    utf16_unit_checker unit_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .fail_count    (fail_count),
        .units_pending (units_pending)
    );

    // one byte request; entered and left at a falling edge
    task automatic send_byte(input logic [7:0] b, input logic end_of_text);
        int gap;
        gap = tx_steady ? 0 : $urandom_range(0, 10);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= end_of_text;
        do
            @(posedge clk);
        while (!s_axis_tready);
        @(negedge clk);
    endtask

    // send text_buf as one string, end flag on its final byte
    task automatic send_text();
        for (int i = 0; i < text_buf.size(); i++)
            send_byte(text_buf[i], i == text_buf.size() - 1);
        bytes_sent += text_buf.size();
    endtask

    // utf-8 encoding of cp in exactly len bytes, overlong if len is more than needed
    function automatic void append_utf8(input logic [20:0] cp, input int len);
        case (len)
            1:
                text_buf.push_back({1'b0, cp[6:0]});
            2:
            begin
                text_buf.push_back({3'b110, cp[10:6]});
                text_buf.push_back({2'b10, cp[5:0]});
            end
            3:
            begin
                text_buf.push_back({4'b1110, cp[15:12]});
                text_buf.push_back({2'b10, cp[11:6]});
                text_buf.push_back({2'b10, cp[5:0]});
            end
            default:
            begin
                text_buf.push_back({5'b11110, cp[20:18]});
                text_buf.push_back({2'b10, cp[17:12]});
                text_buf.push_back({2'b10, cp[11:6]});
                text_buf.push_back({2'b10, cp[5:0]});
            end
        endcase
    endfunction

    // mostly well-formed characters, with some noise and broken sequences
    task automatic build_random_text();
        int         n_chars;
        int         pick;
        int         len;
        int         cut;
        logic [7:0] b;
        text_buf.delete();
        n_chars = $urandom_range(1, 10);
        repeat (n_chars)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 20)
                append_utf8(21'($urandom_range(21'h20, 21'h7e)), 1);
            else if (pick < 25)
                append_utf8(21'($urandom_range(0, 21'h7f)), 1);     // controls and del too
            else if (pick < 43)
                append_utf8(21'($urandom_range(21'h80, 21'h7ff)), 2);
            else if (pick < 62)
                append_utf8(21'($urandom_range(21'h800, 21'hffff)), 3); // surrogates as one
            else if (pick < 80)
                append_utf8(21'($urandom_range(21'h10000, 21'h10ffff)), 4);
            else if (pick < 84)
                append_utf8(21'($urandom_range(0, 21'h1fffff)), 4); // overlong and above max
            else if (pick < 88)
                append_utf8(21'($urandom_range(0, 21'h7f)), $urandom_range(2, 3));
            else if (pick < 92)
            begin
                // sequence cut short; cut by end of string or by the byte that follows
                len = $urandom_range(2, 4);
                append_utf8(21'($urandom_range(0, 21'h1fffff)), len);
                cut = $urandom_range(1, len - 1);
                repeat (cut) void'(text_buf.pop_back());
            end
            else if (pick < 96)
                text_buf.push_back(8'($urandom_range(0, 255)));
            else
            begin
                // lead byte followed by a byte that is no continuation
                len = $urandom_range(2, 4);
                append_utf8(21'($urandom_range(0, 21'h1fffff)), len);
                repeat (len - 1) void'(text_buf.pop_back());
                b = 8'($urandom_range(0, 255));
                if (b[7:6] == 2'b10)
                    b[6] = 1'b1;
                text_buf.push_back(b);
            end
        end
    endtask

    // sender pause: nothing more is offered until every unit has come out
    task automatic wait_drained();
        while (units_pending != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    // receiver: a random wait before each unit, or a long hold when asked
    initial
    begin
        int wait_cycles;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (rx_hold_request)
            begin
                rx_hold_request = 1'b0;
                wait_cycles = LONG_HOLD;
            end
            else
                wait_cycles = rx_steady ? 0 : $urandom_range(0, 10);
            if (wait_cycles > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (wait_cycles) @(negedge clk);
            end
            m_axis_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_axis_tvalid);
            @(negedge clk);
        end
    end

    // run limit
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        int phase;
        int mode;
        int phase_start;

        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // control codes, space, del, tilde, overlong 'A', surrogate written directly
        text_buf = '{8'h00, 8'h1f, 8'h20, 8'h7f, 8'h7e, 8'hc1, 8'h81, 8'hed, 8'ha0, 8'h80};
        send_text();
        // highest code point as a pair, then one just above the limit
        text_buf = '{8'hf4, 8'h8f, 8'hbf, 8'hbf, 8'hf4, 8'h90, 8'h80, 8'h80};
        send_text();
        // stray continuation as lead: rest of string ignored
        text_buf = '{8'h80, 8'h41};
        send_text();
        // bad continuation byte
        text_buf = '{8'hc3, 8'h41};
        send_text();
        // end of string in the middle of a sequence
        text_buf = '{8'he2, 8'h82};
        send_text();
        // 11111xxx lead, alone
        text_buf = '{8'hff};
        send_text();
        s_axis_tvalid <= 1'b0;
        wait_drained();

        // random strings in phases that rotate the idling on both sides
        bytes_sent = 0;
        for (phase = 0; bytes_sent < RANDOM_BYTES; phase++)
        begin
            mode      = phase % 4;
            tx_steady = (mode == 1) || (mode == 2);
            rx_steady = (mode >= 2);
            // one long receiver hold while the sender keeps pushing
            if (phase == 2)
                rx_hold_request = 1'b1;
            phase_start = bytes_sent;
            while (bytes_sent - phase_start < PHASE_BYTES)
            begin
                build_random_text();
                send_text();
            end
            s_axis_tvalid <= 1'b0;
            wait_drained();
        end

        // let any stray unit show up before the verdict
        repeat (10) @(posedge clk);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
